/* hdl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and fixed constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	// Widths of the payload and configuration fields.
	localparam int REQ_W      = 16;
	localparam int REQ_UNIT_W = 13;
	localparam int CFG_W      = 13;
	localparam int OFFSET_W   = 16;

	// Byte requests are rounded up to whole 16-byte units.
	localparam logic [3:0] ROUND_ADD   = 4'hf;
	localparam int         UNIT_SHIFT  = 4;
	localparam int         RESET_UNITS = 4096;
	localparam int         MIN_UNITS   = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_WR_BEST,
		ST_WR_REST,
		ST_DONE
	} bfa_state_t;

	typedef struct packed {
		logic start;
		logic walk;
		logic wr_best;
		logic wr_rest;
		logic load_out;
	} bfa_cmd_t;

	typedef struct packed {
		logic zero_req;
		logic chain_end;
		logic found;
		logic split;
	} bfa_status_t;

endpackage

`default_nettype wire

/* hdl/bfa_dpath.sv */
// ----------------------------------------------------------------------------
// bfa_dpath
// Header store, chain walk with best-fit tracking, block split and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_dpath #(
	parameter int HEAP_UNITS = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire bfa_pkg::bfa_cmd_t           cmd,
	output bfa_pkg::bfa_status_t             status,
	input  wire [bfa_pkg::REQ_W-1:0]         request_bytes,
	input  wire                              cfg_we,
	input  wire [bfa_pkg::CFG_W-1:0]         heap_units_in_use,
	output logic                             granted,
	output logic [bfa_pkg::OFFSET_W-1:0]     data_offset
);

	localparam int UW = $clog2(HEAP_UNITS);
	localparam int EW = 2 * UW + 1;
	localparam int CW = ((UW > bfa_pkg::REQ_UNIT_W) ? UW : bfa_pkg::REQ_UNIT_W) + 2;
	localparam int RESET_SIZE =
		((HEAP_UNITS < bfa_pkg::RESET_UNITS) ? HEAP_UNITS : bfa_pkg::RESET_UNITS) - 1;

	// Header word: next link, size in units, used mark.
	logic [EW-1:0] mem [HEAP_UNITS];
	logic [EW-1:0] rd_q;

	// The header at unit 0 lives in flops so that reset and heap rebuild are
	// immediate.
	logic [UW-1:0] z_link_q;
	logic [UW-1:0] z_size_q;
	logic          z_used_q;

	logic [bfa_pkg::REQ_UNIT_W-1:0] req_q;
	logic                           cur_zero_q;
	logic [UW-1:0]                  cur_addr_q;
	logic                           found_q;
	logic [UW-1:0]                  best_q;
	logic [UW-1:0]                  best_size_q;
	logic [UW-1:0]                  best_next_q;

	logic [bfa_pkg::REQ_W:0]        req_sum;
	logic [bfa_pkg::REQ_UNIT_W-1:0] req_units;
	logic [UW-1:0]                  cur_link;
	logic [UW-1:0]                  cur_size;
	logic                           cur_used;
	logic                           fit;
	logic                           split;
	logic [UW-1:0]                  rest;
	logic [UW-1:0]                  rest_size;
	logic                           wr_en;
	logic [UW-1:0]                  wr_addr;
	logic [EW-1:0]                  wr_data;
	logic [31:0]                    cfg_w;
	logic [31:0]                    cfg_units;
	logic [31:0]                    off_full;

	assign req_sum   = (bfa_pkg::REQ_W + 1)'(request_bytes)
		+ (bfa_pkg::REQ_W + 1)'(bfa_pkg::ROUND_ADD);
	assign req_units = req_sum[bfa_pkg::REQ_W:bfa_pkg::UNIT_SHIFT];

	assign cur_link = cur_zero_q ? z_link_q : rd_q[EW-1:UW+1];
	assign cur_size = cur_zero_q ? z_size_q : rd_q[UW:1];
	assign cur_used = cur_zero_q ? z_used_q : rd_q[0];

	assign fit = !cur_used && (CW'(cur_size) >= CW'(req_q))
		&& (!found_q || (best_size_q > cur_size));

	assign split     = CW'(best_size_q) >= (CW'(req_q) + CW'(2));
	assign rest      = UW'(32'(best_q) + 32'd1 + 32'(req_q));
	assign rest_size = UW'(32'(best_size_q) - 32'(req_q) - 32'd1);

	assign status = bfa_pkg::bfa_status_t'({(request_bytes == '0), (cur_link == '0),
		found_q, split});

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_data = {best_next_q, best_size_q, 1'b1};
		if (cmd.wr_best) begin
			wr_en = 1'b1;
			if (split) begin
				wr_data = {rest, UW'(req_q), 1'b1};
			end
		end else if (cmd.wr_rest) begin
			wr_en   = 1'b1;
			wr_addr = rest;
			wr_data = {best_next_q, rest_size, 1'b0};
		end
	end

	assign cfg_w     = 32'(heap_units_in_use);
	assign cfg_units = (cfg_w < 32'(bfa_pkg::MIN_UNITS)) ? 32'(bfa_pkg::MIN_UNITS) :
		(cfg_w > 32'(HEAP_UNITS)) ? 32'(HEAP_UNITS) : cfg_w;

	assign off_full = (32'(best_q) + 32'd1) << bfa_pkg::UNIT_SHIFT;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr != '0)) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.walk) begin
			rd_q <= mem[cur_link];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_link_q <= '0;
			z_size_q <= UW'(RESET_SIZE);
			z_used_q <= 1'b0;
		end else if (cfg_we) begin
			z_link_q <= '0;
			z_size_q <= UW'(cfg_units - 32'd1);
			z_used_q <= 1'b0;
		end else if (wr_en && (wr_addr == '0)) begin
			z_link_q <= wr_data[EW-1:UW+1];
			z_size_q <= wr_data[UW:1];
			z_used_q <= wr_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			cur_zero_q <= 1'b1;
		end else if (cmd.start) begin
			found_q    <= 1'b0;
			cur_zero_q <= 1'b1;
		end else if (cmd.walk) begin
			cur_zero_q <= 1'b0;
			if (fit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q      <= req_units;
			cur_addr_q <= '0;
		end else if (cmd.walk) begin
			cur_addr_q <= cur_link;
			if (fit) begin
				best_q      <= cur_addr_q;
				best_size_q <= cur_size;
				best_next_q <= cur_link;
			end
		end
		if (cmd.load_out) begin
			granted     <= found_q;
			data_offset <= found_q ? off_full[bfa_pkg::OFFSET_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

/* hdl/bfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the allocator: accept, chain walk, header writes, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	output bfa_pkg::bfa_cmd_t     cmd,
	input  wire bfa_pkg::bfa_status_t status
);

	bfa_pkg::bfa_state_t state_q;
	bfa_pkg::bfa_state_t state_d;
	logic                out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = status.zero_req ? bfa_pkg::ST_DONE : bfa_pkg::ST_WALK;
				end
			end
			bfa_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.chain_end) begin
					state_d = bfa_pkg::ST_WR_BEST;
				end
			end
			bfa_pkg::ST_WR_BEST: begin
				if (status.found) begin
					cmd.wr_best = 1'b1;
					state_d     = status.split ? bfa_pkg::ST_WR_REST : bfa_pkg::ST_DONE;
				end else begin
					state_d = bfa_pkg::ST_DONE;
				end
			end
			bfa_pkg::ST_WR_REST: begin
				cmd.wr_rest = 1'b1;
				state_d     = bfa_pkg::ST_DONE;
			end
			bfa_pkg::ST_DONE: begin
				// The result register may still hold the previous word.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = bfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_rest_after_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_rest |-> $past(cmd.wr_best))
		else $error("tail header written without a preceding head write");

	a_best_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_best |-> $past(cmd.walk))
		else $error("head header written without a finished walk");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while its word waits");

	a_walk_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> !in_ready && !cmd.load_out)
		else $error("walk overlaps accept or result load");
`endif

endmodule

`default_nettype wire

/* hdl/best_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a heap of 16-byte units with a header chain.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_ready    | request_bytes[15:0]
//  out      | out_valid / out_ready  | granted, data_offset[15:0]
//  config   | cfg_we                 | heap_units_in_use[12:0]
//
//  A word passes the accept state, a walk of the chain header by header
//  through the single read port of the header store, the write of the chosen
//  header when a block fits, the write of a split-off free tail, and the
//  result state. A zero request goes from accept straight to the result state.
//  Reset restores one free block spanning the heap at once; no clearing pass.
//  A new word is taken while the previous result still waits on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator #(
	parameter int HEAP_UNITS = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [bfa_pkg::REQ_W-1:0]         request_bytes,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             granted,
	output logic [bfa_pkg::OFFSET_W-1:0]     data_offset,
	input  wire                              cfg_we,
	input  wire [bfa_pkg::CFG_W-1:0]         heap_units_in_use
);

	bfa_pkg::bfa_cmd_t    cmd;
	bfa_pkg::bfa_status_t status;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	bfa_dpath #(
		.HEAP_UNITS (HEAP_UNITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.request_bytes     (request_bytes),
		.cfg_we            (cfg_we),
		.heap_units_in_use (heap_units_in_use),
		.granted           (granted),
		.data_offset       (data_offset)
	);

endmodule

`default_nettype wire

/* tb/tb_best_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Self-checking bench for the best-fit block allocator: a short table of
// directed requests and heap sizes, then random requests over random heap
// sizes under three idling patterns, each word checked against its table
// result or a model of the header chain kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_best_fit_block_allocator;

	localparam int HEAP_UNITS = 4096;

	typedef struct packed {
		logic                         granted;
		logic [bfa_pkg::OFFSET_W-1:0] offset;
	} alloc_result_t;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [15:0]   value;
		bit            typed;
		alloc_result_t want;
	} stim_row_t;

	localparam alloc_result_t REFUSED  = '{granted: 1'b0, offset: 16'd0};
	localparam alloc_result_t FIRST_16 = '{granted: 1'b1, offset: 16'd16};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [bfa_pkg::REQ_W-1:0]    request_bytes;
	logic                         out_valid;
	logic                         out_ready;
	logic                         granted;
	logic [bfa_pkg::OFFSET_W-1:0] data_offset;
	logic                         cfg_we;
	logic [bfa_pkg::CFG_W-1:0]    heap_units_in_use;

	// Model of the header store and the heap length.
	bit [12:0] blk_link [HEAP_UNITS];
	bit [11:0] blk_size [HEAP_UNITS];
	bit        blk_used [HEAP_UNITS];
	int        heap_units;

	alloc_result_t grants_in_flight[$];
	alloc_result_t front_grant;
	int            bad_words;
	int            words_seen;
	int            in_idle_pct;
	int            out_idle_pct;

	// Typed rows can be read straight off the heap layout; the rest go
	// through the model.
	stim_row_t directed_rows [0:30] = '{
		'{ROW_REQ, 16'd0,     1'b1, REFUSED},
		'{ROW_REQ, 16'd65535, 1'b1, REFUSED},
		'{ROW_REQ, 16'd1,     1'b1, FIRST_16},
		'{ROW_REQ, 16'd16,    1'b0, REFUSED},
		'{ROW_REQ, 16'd17,    1'b0, REFUSED},
		'{ROW_REQ, 16'd32,    1'b0, REFUSED},
		'{ROW_REQ, 16'd48,    1'b0, REFUSED},
		'{ROW_REQ, 16'd65520, 1'b0, REFUSED},
		'{ROW_CFG, 16'd0,     1'b0, REFUSED},
		'{ROW_REQ, 16'd16,    1'b1, FIRST_16},
		'{ROW_REQ, 16'd1,     1'b1, REFUSED},
		'{ROW_CFG, 16'd1,     1'b0, REFUSED},
		'{ROW_REQ, 16'd17,    1'b1, REFUSED},
		'{ROW_REQ, 16'd65535, 1'b1, REFUSED},
		'{ROW_CFG, 16'd3,     1'b0, REFUSED},
		'{ROW_REQ, 16'd16,    1'b1, FIRST_16},
		'{ROW_CFG, 16'd4,     1'b0, REFUSED},
		'{ROW_REQ, 16'd16,    1'b1, FIRST_16},
		'{ROW_REQ, 16'd16,    1'b0, REFUSED},
		'{ROW_REQ, 16'd16,    1'b1, REFUSED},
		'{ROW_CFG, 16'd8191,  1'b0, REFUSED},
		'{ROW_REQ, 16'd65520, 1'b1, FIRST_16},
		'{ROW_REQ, 16'd1,     1'b1, REFUSED},
		'{ROW_CFG, 16'd4097,  1'b0, REFUSED},
		'{ROW_REQ, 16'd32768, 1'b0, REFUSED},
		'{ROW_REQ, 16'd32753, 1'b0, REFUSED},
		'{ROW_REQ, 16'd32736, 1'b0, REFUSED},
		'{ROW_CFG, 16'd2,     1'b0, REFUSED},
		'{ROW_REQ, 16'd32,    1'b1, REFUSED},
		'{ROW_CFG, 16'd4096,  1'b0, REFUSED},
		'{ROW_REQ, 16'd15,    1'b0, REFUSED}
	};

	best_fit_block_allocator #(
		.HEAP_UNITS(HEAP_UNITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.request_bytes(request_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted(granted),
		.data_offset(data_offset),
		.cfg_we(cfg_we),
		.heap_units_in_use(heap_units_in_use)
	);

	always #4 clk = ~clk;

	function automatic void apply_heap_units(input logic [bfa_pkg::CFG_W-1:0] units);
		int v;
		v = int'(units);
		if (v < bfa_pkg::MIN_UNITS)
			v = bfa_pkg::MIN_UNITS;
		if (v > HEAP_UNITS)
			v = HEAP_UNITS;
		heap_units = v;
		blk_link[0] = 13'd0;
		blk_size[0] = 12'(v - 1);
		blk_used[0] = 1'b0;
	endfunction

	function automatic void best_fit_alloc(input logic [bfa_pkg::REQ_W-1:0] bytes,
		output alloc_result_t res);
		int  req, cur, steps, best, best_size, best_next, rest;
		bit  found;
		res = REFUSED;
		found = 1'b0;
		best = 0;
		best_size = 0;
		best_next = 0;
		cur = 0;
		req = (int'(bytes) + int'(bfa_pkg::ROUND_ADD)) >> bfa_pkg::UNIT_SHIFT;
		if (req == 0)
			return;
		for (steps = 0; steps < HEAP_UNITS; steps++) begin
			if (cur >= HEAP_UNITS)
				break;
			if (!blk_used[cur] && int'(blk_size[cur]) >= req &&
				(!found || best_size > int'(blk_size[cur]))) begin
				found = 1'b1;
				best = cur;
				best_size = int'(blk_size[cur]);
				best_next = int'(blk_link[cur]);
			end
			if (blk_link[cur] == 13'd0)
				break;
			cur = int'(blk_link[cur]);
		end
		if (!found)
			return;
		// Split only when the leftover holds a header and at least one unit.
		if (best_size >= req + 2) begin
			rest = best + 1 + req;
			blk_link[best] = 13'(rest);
			blk_size[best] = 12'(req);
			blk_used[best] = 1'b1;
			if (rest < HEAP_UNITS) begin
				blk_link[rest] = 13'(best_next);
				blk_size[rest] = 12'(best_size - req - 1);
				blk_used[rest] = 1'b0;
			end
		end else begin
			blk_used[best] = 1'b1;
		end
		res.granted = 1'b1;
		res.offset = 16'((best + 1) << bfa_pkg::UNIT_SHIFT);
	endfunction

	// Mostly requests that fill the heap piece by piece, some aimed at the
	// split boundary of the widest free block, some zero or fully random.
	function automatic logic [bfa_pkg::REQ_W-1:0] pick_request();
		int widest, cur, steps, req, span;
		widest = 0;
		cur = 0;
		for (steps = 0; steps < HEAP_UNITS; steps++) begin
			if (!blk_used[cur] && int'(blk_size[cur]) > widest)
				widest = int'(blk_size[cur]);
			if (blk_link[cur] == 13'd0)
				break;
			cur = int'(blk_link[cur]);
		end
		span = heap_units / 24;
		if (span < 1)
			span = 1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'($urandom);
			2, 3: begin
				req = widest - int'($urandom_range(0, 2));
				if (req < 1)
					req = 1;
				return 16'(req * 16 - int'($urandom_range(0, 15)));
			end
			default: return 16'($urandom_range(1, span * 16));
		endcase
	endfunction

	task automatic flag_word(input string msg);
		bad_words++;
		$display("mismatch at word %0d: %s", words_seen, msg);
	endtask

	task automatic send_word(input logic [bfa_pkg::REQ_W-1:0] bytes, input bit typed,
		input alloc_result_t typed_res);
		alloc_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		request_bytes <= bytes;
		do @(posedge clk); while (!in_ready);
		best_fit_alloc(bytes, predicted);
		grants_in_flight.push_back(typed ? typed_res : predicted);
	endtask

	// The register is only written with the block idle and no result owed.
	task automatic write_heap_units(input logic [bfa_pkg::CFG_W-1:0] units);
		@(negedge clk);
		in_valid <= 1'b0;
		while (grants_in_flight.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		heap_units_in_use <= units;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_heap_units(units);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (grants_in_flight.size() == 0) begin
				flag_word($sformatf("unexpected word granted=%0b offset=%0d",
					granted, data_offset));
			end else begin
				front_grant = grants_in_flight.pop_front();
				if (granted !== front_grant.granted)
					flag_word($sformatf("granted %0b, want %0b",
						granted, front_grant.granted));
				if (data_offset !== front_grant.offset)
					flag_word($sformatf("data_offset %0d, want %0d",
						data_offset, front_grant.offset));
			end
			words_seen++;
		end
	end

	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int                        mode, left, n, k, waited;
		logic [bfa_pkg::CFG_W-1:0] units;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		request_bytes = '0;
		cfg_we = 1'b0;
		heap_units_in_use = bfa_pkg::CFG_W'(bfa_pkg::RESET_UNITS);
		bad_words = 0;
		words_seen = 0;
		in_idle_pct = 28;
		out_idle_pct = 67;
		apply_heap_units(bfa_pkg::CFG_W'(bfa_pkg::RESET_UNITS));
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_heap_units(directed_rows[i].value[bfa_pkg::CFG_W-1:0]);
			else
				send_word(directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].want);
		end

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin in_idle_pct = 28; out_idle_pct = 67; end
				1: begin in_idle_pct = 67; out_idle_pct = 28; end
				default: begin in_idle_pct = 0; out_idle_pct = 0; end
			endcase
			left = 133;
			while (left > 0) begin
				case ($urandom_range(0, 9))
					0: units = bfa_pkg::CFG_W'($urandom_range(0, 2));
					1: units = bfa_pkg::CFG_W'($urandom_range(3, 8));
					2, 3: units = bfa_pkg::CFG_W'(HEAP_UNITS);
					4: units = bfa_pkg::CFG_W'($urandom_range(HEAP_UNITS + 1, 8191));
					default: units = bfa_pkg::CFG_W'($urandom_range(9, 600));
				endcase
				write_heap_units(units);
				n = $urandom_range(8, 60);
				if (n > left)
					n = left;
				for (k = 0; k < n; k++)
					send_word(pick_request(), 1'b0, REFUSED);
				left -= n;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		for (waited = 0; grants_in_flight.size() != 0 && waited < 100000; waited++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (grants_in_flight.size() != 0)
			flag_word($sformatf("%0d results never arrived", grants_in_flight.size()));
		if (bad_words == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
